>>> rtl/fsbw_pkg.sv
// fsbw_pkg: command and status codes, register indexes, control structs and the
// BMP header byte function of the frame store BMP writer. No dependencies.
package fsbw_pkg;

	localparam int HDR_BYTES = 54;
	localparam int INFO_BYTES = 40;
	localparam int BITS_PER_PX = 24;

	// size register indexes on the write port
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ACT_SET   = 2'd0,
		ACT_FILL  = 2'd1,
		ACT_START = 2'd2,
		ACT_FETCH = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_BYTE = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic    valid;
		action_t act;
		logic    ok;
	} q_ctl_t;

	// back end towards the front end
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_st_t;

	function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [5:0] pos);
		logic [1:0] p;
		p = pos[1:0];
		return 8'(v >> {p, 3'b000});
	endfunction

	// idx counts from 0; the two size fields carry the effective size
	function automatic logic [7:0] header_byte(input logic [5:0] idx, input logic [31:0] w,
			input logic [31:0] h, input logic [31:0] img);
		logic [7:0] b;
		b = 8'h00;
		priority if (idx == 6'd0) b = 8'h42;
		else if (idx == 6'd1) b = 8'h4D;
		else if (idx < 6'd6) b = le_byte(img + 32'(HDR_BYTES), idx - 6'd2);
		else if (idx < 6'd10) b = 8'h00;
		else if (idx < 6'd14) b = le_byte(32'(HDR_BYTES), idx - 6'd10);
		else if (idx < 6'd18) b = le_byte(32'(INFO_BYTES), idx - 6'd14);
		else if (idx < 6'd22) b = le_byte(w, idx - 6'd18);
		else if (idx < 6'd26) b = le_byte(h, idx - 6'd22);
		else if (idx < 6'd28) b = le_byte(32'd1, idx - 6'd26);
		else if (idx < 6'd30) b = le_byte(32'(BITS_PER_PX), idx - 6'd28);
		else if (idx < 6'd34) b = 8'h00;
		else if (idx < 6'd38) b = le_byte(img, idx - 6'd34);
		else b = 8'h00;
		return b;
	endfunction

endpackage

>>> rtl/fsbw_ram.sv
// fsbw_ram: generic simple dual port RAM, one write and one registered read.
// No dependencies.
module fsbw_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/fsbw_front.sv
// fsbw_front: takes commands, clips fill rectangles to the frame, checks set
// pixel coordinates and holds them in a two entry queue for the back end. Uses fsbw_pkg.
module fsbw_front import fsbw_pkg::*; #(
	parameter int XW = 8,
	parameter int YW = 8,
	parameter int EW = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [15:0]       x_first,
	input  logic [15:0]       y_first,
	input  logic [15:0]       x_second,
	input  logic [15:0]       y_second,
	input  logic [23:0]       pixel_color,
	input  logic [EW-1:0]     w_eff,
	input  logic [EW-1:0]     h_eff,
	input  back_st_t          bst,
	output q_ctl_t            head,
	output logic [XW-1:0]     head_xl,
	output logic [YW-1:0]     head_yl,
	output logic [XW-1:0]     head_xh,
	output logic [YW-1:0]     head_yh,
	output logic [23:0]       head_color
);
	logic signed [16:0] x1s, y1s, x2s, y2s, wm1, hm1, xl, yl, xh, yh;
	logic               ok;
	logic               acc;

	action_t      act_q [2];
	logic         ok_q [2];
	logic [XW-1:0] xl_q [2];
	logic [YW-1:0] yl_q [2];
	logic [XW-1:0] xh_q [2];
	logic [YW-1:0] yh_q [2];
	logic [23:0]  col_q [2];
	logic         rd_q, wr_q;
	logic [1:0]   cnt_q;

	assign x1s = {x_first[15], x_first};
	assign y1s = {y_first[15], y_first};
	assign x2s = {x_second[15], x_second};
	assign y2s = {y_second[15], y_second};
	assign wm1 = $signed(17'(w_eff)) - 17'sd1;
	assign hm1 = $signed(17'(h_eff)) - 17'sd1;

	always_comb begin
		xl = (x1s < 0) ? 17'sd0 : x1s;
		yl = (y1s < 0) ? 17'sd0 : y1s;
		xh = (x2s > wm1) ? wm1 : x2s;
		yh = (y2s > hm1) ? hm1 : y2s;
		if (action_t'(action) == ACT_SET) begin
			ok = (x1s >= 0) && (x1s <= wm1) && (y1s >= 0) && (y1s <= hm1);
			xl = x1s;
			yl = y1s;
		end else begin
			ok = (xl <= xh) && (yl <= yh);
		end
	end

	assign busy = (cnt_q == 2'd2) || bst.clearing;
	assign acc  = start && !busy;

	always_ff @(posedge clk) begin
		if (acc) begin
			act_q[wr_q] <= action_t'(action);
			ok_q[wr_q]  <= ok;
			xl_q[wr_q]  <= XW'(xl);
			yl_q[wr_q]  <= YW'(yl);
			xh_q[wr_q]  <= XW'(xh);
			yh_q[wr_q]  <= YW'(yh);
			col_q[wr_q] <= pixel_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) wr_q <= !wr_q;
			if (bst.pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(bst.pop);
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.act   = act_q[rd_q];
	assign head.ok    = ok_q[rd_q];
	assign head_xl    = xl_q[rd_q];
	assign head_yl    = yl_q[rd_q];
	assign head_xh    = xh_q[rd_q];
	assign head_yh    = yh_q[rd_q];
	assign head_color = col_q[rd_q];

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		bst.pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> busy) else $error("accept possible while full");
endmodule

>>> rtl/fsbw_back.sv
// fsbw_back: executes queued commands on the frame store, streams the BMP
// file and drives the result strobe. Uses fsbw_pkg and fsbw_ram.
module fsbw_back import fsbw_pkg::*; #(
	parameter int XW = 8,
	parameter int YW = 8,
	parameter int EW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_kill,
	input  logic [EW-1:0] w_eff,
	input  logic [EW-1:0] h_eff,
	input  q_ctl_t        head,
	input  logic [XW-1:0] head_xl,
	input  logic [YW-1:0] head_yl,
	input  logic [XW-1:0] head_xh,
	input  logic [YW-1:0] head_yh,
	input  logic [23:0]   head_color,
	output back_st_t      bst,
	output logic          done,
	output logic [1:0]    status,
	output logic [7:0]    data_byte,
	output logic          is_last
);
	localparam int AW = XW + YW;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_FILL  = 4'b0100,
		S_READ  = 4'b1000
	} state_t;

	state_t        st_q;
	logic [AW-1:0] clr_q;
	logic [XW-1:0] fx_q, fxl_q, fxh_q;
	logic [YW-1:0] fy_q, fyh_q;
	logic [23:0]   fcol_q;
	logic          act_q;
	logic [5:0]    hdr_q;
	logic [YW-1:0] row_q;
	logic [XW-1:0] col_q;
	logic [1:0]    ph_q, padc_q;
	logic [31:0]   img_q;
	logic          done_q, last_q;
	status_t       status_q;
	logic [7:0]    data_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [23:0]   wdata, rdata;
	logic [1:0]    pad;
	logic [31:0]   w32, h32;
	logic          row_end, file_end;
	logic [7:0]    px_byte;

	assign w32 = 32'(w_eff);
	assign h32 = 32'(h_eff);
	assign pad = 2'(w32);  // 3*w mod 4 pads by w mod 4
	assign row_end  = (32'(col_q) + 32'd1) >= w32;
	assign file_end = (32'(row_q) + 32'd1) >= h32;
	assign raddr = {YW'(h32 - 32'd1 - 32'(row_q)), col_q};

	always_comb begin
		unique case (ph_q)
			2'd0: px_byte = rdata[7:0];
			2'd1: px_byte = rdata[15:8];
			default: px_byte = rdata[23:16];
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = 24'h000000;
		unique case (st_q)
			S_CLEAR: we = 1'b1;
			S_FILL: begin
				we    = 1'b1;
				waddr = {fy_q, fx_q};
				wdata = fcol_q;
			end
			S_IDLE: begin
				we    = head.valid && head.act == ACT_SET && head.ok;
				waddr = {head_yl, head_xl};
				wdata = head_color;
			end
			default: we = 1'b0;
		endcase
	end

	assign bst.pop      = (st_q == S_IDLE) && head.valid;
	assign bst.clearing = (st_q == S_CLEAR);

	fsbw_ram #(.WIDTH(24), .DEPTH(2 ** AW)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// image size, product registered; config is stable long before a fetch
	always_ff @(posedge clk) begin
		img_q <= (w32 * 32'd3 + 32'(pad)) * h32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLEAR;
			clr_q    <= '0;
			act_q    <= 1'b0;
			hdr_q    <= 6'd0;
			row_q    <= '0;
			col_q    <= '0;
			ph_q     <= 2'd0;
			padc_q   <= 2'd0;
			done_q   <= 1'b0;
			last_q   <= 1'b0;
			status_q <= ST_DONE;
			data_q   <= 8'h00;
			fx_q     <= '0;
			fy_q     <= '0;
			fxl_q    <= '0;
			fxh_q    <= '0;
			fyh_q    <= '0;
			fcol_q   <= '0;
		end else begin
			done_q   <= 1'b0;
			last_q   <= 1'b0;
			status_q <= ST_DONE;
			data_q   <= 8'h00;
			if (cfg_kill) act_q <= 1'b0;
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (head.valid) begin
						unique case (head.act)
							ACT_SET: done_q <= 1'b1;
							ACT_FILL: begin
								if (head.ok) begin
									fx_q   <= head_xl;
									fy_q   <= head_yl;
									fxl_q  <= head_xl;
									fxh_q  <= head_xh;
									fyh_q  <= head_yh;
									fcol_q <= head_color;
									st_q   <= S_FILL;
								end else begin
									done_q <= 1'b1;
								end
							end
							ACT_START: begin
								act_q  <= 1'b1;
								hdr_q  <= 6'd0;
								row_q  <= '0;
								col_q  <= '0;
								ph_q   <= 2'd0;
								padc_q <= 2'd0;
								done_q <= 1'b1;
							end
							default: begin
								if (!act_q) begin
									done_q   <= 1'b1;
									status_q <= ST_NONE;
								end else if (32'(hdr_q) < HDR_BYTES) begin
									done_q   <= 1'b1;
									status_q <= ST_BYTE;
									data_q   <= header_byte(hdr_q, w32, h32, img_q);
									hdr_q    <= hdr_q + 6'd1;
								end else if (ph_q == 2'd3) begin
									done_q   <= 1'b1;
									status_q <= ST_BYTE;
									padc_q   <= padc_q + 2'd1;
									if (padc_q + 2'd1 >= pad) begin
										ph_q   <= 2'd0;
										padc_q <= 2'd0;
										col_q  <= '0;
										if (file_end) begin
											act_q  <= 1'b0;
											last_q <= 1'b1;
										end else begin
											row_q <= row_q + 1'b1;
										end
									end
								end else begin
									st_q <= S_READ;
								end
							end
						endcase
					end
				end
				S_FILL: begin
					if (fx_q == fxh_q) begin
						fx_q <= fxl_q;
						if (fy_q == fyh_q) begin
							done_q <= 1'b1;
							st_q   <= S_IDLE;
						end else begin
							fy_q <= fy_q + 1'b1;
						end
					end else begin
						fx_q <= fx_q + 1'b1;
					end
				end
				S_READ: begin
					done_q   <= 1'b1;
					status_q <= ST_BYTE;
					data_q   <= px_byte;
					st_q     <= S_IDLE;
					if (ph_q != 2'd2) begin
						ph_q <= ph_q + 2'd1;
					end else if (!row_end) begin
						ph_q  <= 2'd0;
						col_q <= col_q + 1'b1;
					end else if (pad != 2'd0) begin
						ph_q   <= 2'd3;
						padc_q <= 2'd0;
					end else begin
						ph_q  <= 2'd0;
						col_q <= '0;
						if (file_end) begin
							act_q  <= 1'b0;
							last_q <= 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign data_byte = data_q;
	assign is_last   = last_q;

	a_no_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CLEAR |-> !done_q) else $error("result during clearing pass");
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q != ST_BYTE |-> data_q == 8'h00 && !last_q)
		else $error("non-byte result carries data");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && last_q |-> !act_q) else $error("export still active after last byte");
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_READ |=> done_q && status_q == ST_BYTE)
		else $error("pixel read gave no byte");
endmodule

>>> rtl/frame_store_bmp_writer_core.sv
// frame_store_bmp_writer_core: top level, size registers and the front and
// back ends. Uses fsbw_pkg, fsbw_front, fsbw_back.
//
// Commands are taken when start is high and busy low; each gives one result
// on done for one cycle, which the receiver must take. Set pixel, start and
// header or padding fetch are answered from the idle state; a pixel byte
// fetch passes through a read state for the registered frame store read; a
// fill writes its clipped rectangle one pixel per cycle. A two entry queue
// lets new commands in while one runs. After reset the frame store is
// cleared one word a cycle, all 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) words
// (65536 by default), with busy high; size registers may be written meanwhile.
module frame_store_bmp_writer_core import fsbw_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [15:0] x_first,
	input  logic [15:0] y_first,
	input  logic [15:0] x_second,
	input  logic [15:0] y_second,
	input  logic [23:0] pixel_color,
	output logic        done,
	output logic [1:0]  status,
	output logic [7:0]  data_byte,
	output logic        is_last,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [8:0]  cfg_wdata
);
	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int EMAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int EW = $clog2(EMAX + 1);

	logic [8:0]    width_q, height_q;
	logic [EW-1:0] w_eff, h_eff;
	back_st_t      bst;
	q_ctl_t        head;
	logic [XW-1:0] head_xl, head_xh;
	logic [YW-1:0] head_yl, head_yh;
	logic [23:0]   head_color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd64;
			height_q <= 9'd64;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WIDTH:  width_q  <= cfg_wdata;
				default:    height_q <= cfg_wdata;
			endcase
		end
	end

	always_comb begin
		if (width_q == 9'd0) w_eff = EW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = EW'(MAX_WIDTH);
		else w_eff = EW'(width_q);
		if (height_q == 9'd0) h_eff = EW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = EW'(MAX_HEIGHT);
		else h_eff = EW'(height_q);
	end

	fsbw_front #(.XW(XW), .YW(YW), .EW(EW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.x_first    (x_first),
		.y_first    (y_first),
		.x_second   (x_second),
		.y_second   (y_second),
		.pixel_color(pixel_color),
		.w_eff      (w_eff),
		.h_eff      (h_eff),
		.bst        (bst),
		.head       (head),
		.head_xl    (head_xl),
		.head_yl    (head_yl),
		.head_xh    (head_xh),
		.head_yh    (head_yh),
		.head_color (head_color)
	);

	fsbw_back #(.XW(XW), .YW(YW), .EW(EW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_kill  (cfg_we && (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT)),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.head      (head),
		.head_xl   (head_xl),
		.head_yl   (head_yl),
		.head_xh   (head_xh),
		.head_yh   (head_yh),
		.head_color(head_color),
		.bst       (bst),
		.done      (done),
		.status    (status),
		.data_byte (data_byte),
		.is_last   (is_last)
	);
endmodule

>>> verif/fsbw_checker.sv
// fsbw_checker: watches the command, result and register ports of the frame store
// BMP writer, predicts each result word and compares it. Uses fsbw_pkg.
module fsbw_checker import fsbw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  action,
	input  logic [15:0] x_first,
	input  logic [15:0] y_first,
	input  logic [15:0] x_second,
	input  logic [15:0] y_second,
	input  logic [23:0] pixel_color,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [8:0]  cfg_wdata,
	output int          fail_count,
	output int          open_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t    st;
		logic [7:0] b;
		logic       last;
	} word_t;

	logic [23:0] pixels [0:65535];
	logic [8:0]  width_reg, height_reg;
	bit          exporting;
	int          hdr_sent, rows_done, col, phase, pads;
	word_t       expected_words[$];

	function automatic int frame_w();
		return width_reg == 0 ? 1 : (width_reg > 256 ? 256 : int'(width_reg));
	endfunction

	function automatic int frame_h();
		return height_reg == 0 ? 1 : (height_reg > 256 ? 256 : int'(height_reg));
	endfunction

	function automatic int row_pad_bytes();
		return (4 - ((frame_w() * 3) % 4)) % 4;
	endfunction

	function automatic logic [7:0] le8(int unsigned v, int pos);
		return 8'(v >> (8 * (pos % 4)));
	endfunction

	function automatic logic [7:0] file_header(int i);
		int unsigned img;
		img = (frame_w() * 3 + row_pad_bytes()) * frame_h();
		if (i == 0) return 8'h42;
		if (i == 1) return 8'h4D;
		if (i < 6) return le8(img + HDR_BYTES, i - 2);
		if (i < 10) return 8'h00;
		if (i < 14) return le8(HDR_BYTES, i - 10);
		if (i < 18) return le8(INFO_BYTES, i - 14);
		if (i < 22) return le8(frame_w(), i - 18);
		if (i < 26) return le8(frame_h(), i - 22);
		if (i < 28) return le8(1, i - 26);
		if (i < 30) return le8(BITS_PER_PX, i - 28);
		if (i < 34) return 8'h00;
		if (i < 38) return le8(img, i - 34);
		return 8'h00;
	endfunction

	function automatic void paint(int x, int y, logic [23:0] c);
		if (x < 0 || y < 0 || x >= frame_w() || y >= frame_h())
			return;
		pixels[y * 256 + x] = c;
	endfunction

	// true when the finished row was the top one
	function automatic bit close_row();
		phase = 0;
		pads = 0;
		col = 0;
		if (rows_done + 1 >= frame_h()) begin
			exporting = 0;
			return 1;
		end
		rows_done++;
		return 0;
	endfunction

	function automatic word_t predict_word(action_t a, int x1, int y1, int x2, int y2,
			logic [23:0] c);
		word_t r;
		int xl, yl, xh, yh, w, h, pad, rw, cl;
		logic [23:0] p;
		r.st = ST_DONE;
		r.b = 8'h00;
		r.last = 0;
		w = frame_w();
		h = frame_h();
		pad = row_pad_bytes();
		case (a)
			ACT_SET: paint(x1, y1, c);
			ACT_FILL: begin
				xl = x1 < 0 ? 0 : x1;
				yl = y1 < 0 ? 0 : y1;
				xh = x2 > w - 1 ? w - 1 : x2;
				yh = y2 > h - 1 ? h - 1 : y2;
				for (int y = yl; y <= yh; y++)
					for (int x = xl; x <= xh; x++)
						paint(x, y, c);
			end
			ACT_START: begin
				exporting = 1;
				hdr_sent = 0;
				rows_done = 0;
				col = 0;
				phase = 0;
				pads = 0;
			end
			default: begin
				if (!exporting) begin
					r.st = ST_NONE;
				end else begin
					r.st = ST_BYTE;
					if (hdr_sent < HDR_BYTES) begin
						r.b = file_header(hdr_sent);
						hdr_sent++;
					end else if (phase == 3) begin
						pads++;
						if (pads >= pad)
							r.last = close_row();
					end else begin
						rw = rows_done < h ? rows_done : h - 1;
						cl = col < w ? col : w - 1;
						p = pixels[(h - 1 - rw) * 256 + cl];
						r.b = phase == 0 ? p[7:0] : (phase == 1 ? p[15:8] : p[23:16]);
						phase++;
						if (phase == 3) begin
							if (cl + 1 >= w) begin
								if (pad > 0)
									pads = 0;
								else
									r.last = close_row();
							end else begin
								phase = 0;
								col = cl + 1;
							end
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("ERROR at %0t: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t e;
		if (!arst_n) begin
			foreach (pixels[i])
				pixels[i] = 24'h0;
			width_reg = 9'd64;
			height_reg = 9'd64;
			exporting = 0;
			hdr_sent = 0;
			rows_done = 0;
			col = 0;
			phase = 0;
			pads = 0;
			expected_words.delete();
			fail_count = 0;
			open_count = 0;
		end else begin
			if (done) begin
				if (expected_words.size() == 0) begin
					report_mismatch("result word with none expected");
				end else begin
					e = expected_words.pop_front();
					if (status != e.st)
						report_mismatch($sformatf("status %0d, expected %0d", status, e.st));
					if (data_byte != e.b)
						report_mismatch($sformatf("data_byte %02h, expected %02h",
							data_byte, e.b));
					if (is_last != e.last)
						report_mismatch($sformatf("is_last %0b, expected %0b", is_last, e.last));
				end
			end
			if (cfg_we) begin
				if (cfg_addr == REG_WIDTH)
					width_reg = cfg_wdata;
				else
					height_reg = cfg_wdata;
				exporting = 0;
			end
			if (start && !busy)
				expected_words.push_back(predict_word(action_t'(action),
					int'($signed(x_first)), int'($signed(y_first)),
					int'($signed(x_second)), int'($signed(y_second)), pixel_color));
			open_count = expected_words.size();
		end
	end

endmodule

>>> verif/tb_frame_store_bmp_writer_core.sv
// tb_frame_store_bmp_writer_core: drives commands and size writes into the frame
// store BMP writer and gives the verdict. Uses fsbw_pkg and fsbw_checker.
module tb_frame_store_bmp_writer_core import fsbw_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 700;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [1:0]  action = ACT_SET;
	logic [15:0] x_first = '0, y_first = '0, x_second = '0, y_second = '0;
	logic [23:0] pixel_color = '0;
	logic        done;
	logic [1:0]  status;
	logic [7:0]  data_byte;
	logic        is_last;
	logic        cfg_we = 0;
	logic        cfg_addr = 0;
	logic [8:0]  cfg_wdata = '0;
	int          fail_count, open_count;
	int          sent = 0;
	int          idle_pct = 6;
	int          eff_w = 64, eff_h = 64;

	frame_store_bmp_writer_core u_top (.*);
	fsbw_checker u_chk (.*);

	always #5 clk = ~clk;

	initial begin
		#50ms;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic issue(action_t a, logic [15:0] x1, logic [15:0] y1, logic [15:0] x2,
			logic [15:0] y2, logic [23:0] c);
		start <= 1'b1;
		action <= a;
		x_first <= x1;
		y_first <= y1;
		x_second <= x2;
		y_second <= y2;
		pixel_color <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		if (sent < ITEM_TARGET / 3)
			idle_pct = 6;
		else if (sent < 2 * ITEM_TARGET / 3)
			idle_pct = 65;
		else
			idle_pct = 0;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	task automatic fetch_bytes(int n);
		repeat (n)
			issue(ACT_FETCH, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				24'($urandom));
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic set_size(logic [8:0] w, logic [8:0] h);
		settle();
		cfg_we <= 1'b1;
		cfg_addr <= REG_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_addr <= REG_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		eff_w = w == 0 ? 1 : (w > 256 ? 256 : w);
		eff_h = h == 0 ? 1 : (h > 256 ? 256 : h);
	endtask

	function automatic int file_bytes();
		return 54 + (eff_w * 3 + (4 - (eff_w * 3) % 4) % 4) * eff_h;
	endfunction

	// mostly near the frame, sometimes anywhere in the 16-bit range
	function automatic logic [15:0] coord(int lim);
		if ($urandom_range(9) < 8)
			return 16'($urandom_range(0, lim + 1) - 1);
		return 16'($urandom);
	endfunction

	task automatic paint_word();
		logic [15:0] xa, ya;
		xa = coord(eff_w);
		ya = coord(eff_h);
		if ($urandom_range(2) == 0)
			issue(ACT_SET, xa, ya, 16'($urandom), 16'($urandom), 24'($urandom));
		else
			issue(ACT_FILL, xa, ya, coord(eff_w), coord(eff_h), 24'($urandom));
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed: default 64x64 frame
		issue(ACT_FETCH, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0);
		issue(ACT_SET, 16'h8000, 16'h0, 16'h0, 16'h0, 24'hFFFFFF);
		issue(ACT_SET, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		issue(ACT_SET, 16'd0, 16'd63, 16'h0, 16'h0, 24'h123456);
		issue(ACT_SET, 16'd63, 16'd0, 16'h0, 16'h0, 24'hA5C3F0);
		issue(ACT_SET, 16'd64, 16'd5, 16'h0, 16'h0, 24'h0F0F0F);
		issue(ACT_FILL, 16'd10, 16'd10, 16'd9, 16'd20, 24'hFFFFFF);
		issue(ACT_FILL, 16'd10, 16'd10, 16'd20, 16'd9, 24'hFFFFFF);
		issue(ACT_FILL, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 24'h5A5A5A);
		issue(ACT_FILL, 16'd60, 16'd62, 16'd70, 16'd70, 24'hFF00FF);
		issue(ACT_START, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0);
		fetch_bytes(60);
		issue(ACT_SET, 16'd1, 16'd63, 16'h0, 16'h0, 24'hC0FFEE);
		issue(ACT_START, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0);
		fetch_bytes(70);

		// size extremes, header and first pixels only
		set_size(9'd511, 9'd0);
		issue(ACT_FILL, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 24'h00FF00);
		issue(ACT_SET, 16'd255, 16'd0, 16'h0, 16'h0, 24'hABCDEF);
		issue(ACT_START, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0);
		fetch_bytes(80);
		set_size(9'd0, 9'd511);
		issue(ACT_FILL, 16'h0, 16'd100, 16'h0, 16'd300, 24'h0000FF);
		issue(ACT_START, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0);
		fetch_bytes(80);
		set_size(9'd256, 9'd256);
		issue(ACT_FILL, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 24'h800001);
		issue(ACT_START, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0);
		fetch_bytes(70);
		// a size write cuts the export short
		set_size(9'd1, 9'd1);
		fetch_bytes(2);
		issue(ACT_START, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0);
		fetch_bytes(file_bytes() + 1);

		while (sent < ITEM_TARGET) begin
			if ($urandom_range(9) == 0)
				set_size(9'($urandom_range(9, 32)), 9'($urandom_range(1, 3)));
			else
				set_size(9'($urandom_range(0, 8)), 9'($urandom_range(0, 8)));
			repeat ($urandom_range(2, 10))
				case ($urandom_range(9))
					0: fetch_bytes(1);
					1: issue(ACT_START, 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 24'($urandom));
					default: paint_word();
				endcase
			issue(ACT_START, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				24'($urandom));
			for (int i = 0; i < file_bytes() + $urandom_range(0, 2); i++) begin
				if ($urandom_range(19) == 0)
					paint_word();
				fetch_bytes(1);
			end
		end

		settle();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
